// File: design/vpid_pkg.sv
// vpid_pkg: shared types and constants of the vector pid controller
`default_nettype none

package vpid_pkg;

    localparam int AXES      = 3;
    localparam int GAIN_REGS = 3;
    localparam int GROUP_W   = 2;
    localparam int VALUE_W   = 32;
    localparam int DT_W      = 16;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int INT_W     = 48;
    localparam int MUL_A_W   = INT_W;
    localparam int MUL_B_W   = GAIN_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 58;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 2'd2;

    localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic        [GROUP_W-1:0] group_t;
    typedef logic        [DT_W-1:0]    step_t;
    typedef logic        [CFG_W-1:0]   gains_t;
    typedef logic signed [INT_W-1:0]   integ_t;

endpackage

`default_nettype wire

// File: design/vpid_if.sv
// vpid_if: valid/ready channels for items, results and gain writes
`default_nettype none

interface vpid_req_if import vpid_pkg::*;;
    logic   valid;
    logic   ready;
    group_t vector_group;
    value_t actual_x;
    value_t actual_y;
    value_t actual_z;
    value_t target_x;
    value_t target_y;
    value_t target_z;
    step_t  step_time;

    modport source (output valid, vector_group, actual_x, actual_y, actual_z,
                    target_x, target_y, target_z, step_time, input ready);
    modport sink   (input valid, vector_group, actual_x, actual_y, actual_z,
                    target_x, target_y, target_z, step_time, output ready);
endinterface

interface vpid_rsp_if import vpid_pkg::*;;
    logic   valid;
    logic   ready;
    group_t out_group;
    value_t drive_x;
    value_t drive_y;
    value_t drive_z;

    modport source (output valid, out_group, drive_x, drive_y, drive_z, input ready);
    modport sink   (input valid, out_group, drive_x, drive_y, drive_z, output ready);
endinterface

interface vpid_cfg_if import vpid_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    gains_t               wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// File: design/vpid_mul.sv
// vpid_mul: shared signed multiplier with registered product
`default_nettype none

module vpid_mul
    import vpid_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic signed [MUL_A_W-1:0] mul_a,
    input  wire logic signed [MUL_B_W-1:0] mul_b,
    output      logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: design/vpid_div.sv
// vpid_div: unsigned restoring divider, two quotient bits per cycle
`default_nettype none

module vpid_div
    import vpid_pkg::*;
#(
    parameter int DIVIDEND_W = 50
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire step_t                 divisor,
    output      logic                  busy,
    output      logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEPS = DIVIDEND_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DT_W-1:0]       rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    step_t                 dvs_reg, dvs_next;

    always_comb
    begin
        logic [DT_W:0]         trial;
        logic [DT_W-1:0]       rem_w;
        logic [DIVIDEND_W-1:0] quo_w;
        rem_w     = rem_reg;
        quo_w     = quo_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial = {rem_w, quo_w[DIVIDEND_W-1]};
            quo_w = {quo_w[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial    = trial - {1'b0, dvs_reg};
                quo_w[0] = 1'b1;
            end
            rem_w = trial[DT_W-1:0];
        end
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = rem_w;
            quo_next = quo_w;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: design/vector_pid_controller.sv
// vector_pid_controller: three-axis pid controller with shared multiplier and divider
//
//  channel | role  | handshake     | payload
//  req     | sink  | valid / ready | vector_group, actual_x/y/z, target_x/y/z, step_time
//  rsp     | src   | valid / ready | out_group, drive_x/y/z
//  cfg     | sink  | valid / ready | index, wdata (always ready)
//
//  one transaction works through the three axes in turn: each axis waits on the
//  two-bit-per-cycle divider for the derivative
//  a zero step time skips the divider
//  a group outside the valid range skips the axes and returns zero drives
//  req is ready only when idle; a stalled result holds the block until rsp takes it
//  reset clears gains, integrals and previous errors at once
`default_nettype none

module vector_pid_controller
    import vpid_pkg::*;
#(
    parameter int NUM_GROUPS = 3,
    parameter int DATA_WIDTH = 32
)
(
    input wire logic   clk,
    input wire logic   rst_n,
    vpid_req_if.sink   req,
    vpid_rsp_if.source rsp,
    vpid_cfg_if.sink   cfg
);

    localparam int VAL_BITS    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int EW          = VAL_BITS + 1;
    localparam int DIVIDEND_W  = ((VAL_BITS + 18 + 1) / 2) * 2;
    localparam int STORE_DEPTH = AXES * NUM_GROUPS;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ERR   = 4'd1;
    localparam logic [3:0] ST_MULI  = 4'd2;
    localparam logic [3:0] ST_INTG  = 4'd3;
    localparam logic [3:0] ST_PROP  = 4'd4;
    localparam logic [3:0] ST_ITGM  = 4'd5;
    localparam logic [3:0] ST_DWAIT = 4'd6;
    localparam logic [3:0] ST_DMUL  = 4'd7;
    localparam logic [3:0] ST_ACCD  = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    localparam logic signed [ACC_W-1:0] V_MAX =
        ACC_W'((64'sd1 <<< (VAL_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] V_MIN = -V_MAX - ACC_W'(1);
    localparam logic [63:0] D_LIM = 64'd1 << (INT_W - 1);

    logic [3:0]              state_reg, state_next;
    logic [1:0]              axis_reg, axis_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    group_t                  grp_reg, grp_next;
    step_t                   dt_reg, dt_next;
    value_t                  act_reg [AXES];
    value_t                  act_next [AXES];
    value_t                  tgt_reg [AXES];
    value_t                  tgt_next [AXES];
    logic signed [EW-1:0]    e_reg, e_next;
    integ_t                  i_reg, i_next;
    integ_t                  d_reg, d_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    value_t                  drive_reg [AXES];
    value_t                  drive_next [AXES];
    group_t                  out_group_reg, out_group_next;
    gains_t                  gain_reg [GAIN_REGS];
    gains_t                  gain_next [GAIN_REGS];
    integ_t                  integ_reg [STORE_DEPTH];
    integ_t                  integ_next [STORE_DEPTH];
    logic signed [EW-1:0]    prev_reg [STORE_DEPTH];
    logic signed [EW-1:0]    prev_next [STORE_DEPTH];

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic                  div_busy;
    logic [DIVIDEND_W-1:0] div_quotient;

    logic                    grp_ok;
    logic                    req_fire;
    logic                    rsp_fire;
    logic signed [GAIN_W-1:0] kp, ki, kd;
    logic signed [EW-1:0]    e_calc;
    logic signed [EW:0]      diff;
    logic [EW:0]             diff_mag;
    logic signed [INT_W+1:0] integ_sum;
    integ_t                  integ_sat;
    logic [63:0]             quo_ext;
    integ_t                  d_sat;
    logic signed [ACC_W-1:0] prod_term;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] acc_sat;

    assign req_fire = req.valid && req.ready;
    assign rsp_fire = rsp.valid && rsp.ready;
    assign grp_ok   = (32'(req.vector_group) < NUM_GROUPS)
                   && (req.vector_group < GROUP_W'(GAIN_REGS));

    assign kp = gain_reg[grp_reg][GAIN_W-1:0];
    assign ki = gain_reg[grp_reg][2*GAIN_W-1:GAIN_W];
    assign kd = gain_reg[grp_reg][3*GAIN_W-1:2*GAIN_W];

    // error and derivative numerator of the current axis
    assign e_calc   = EW'($signed(tgt_reg[axis_reg][VAL_BITS-1:0]))
                    - EW'($signed(act_reg[axis_reg][VAL_BITS-1:0]));
    assign diff     = (EW+1)'(e_reg) - (EW+1)'(prev_reg[idx_reg]);
    assign diff_mag = diff[EW] ? $unsigned(-diff) : $unsigned(diff);

    assign div_start    = (state_reg == ST_MULI) && (dt_reg != '0);
    assign div_dividend = DIVIDEND_W'({diff_mag, {DT_W{1'b0}}});

    // integral update, product holds e * dt here
    assign integ_sum = (INT_W+2)'(integ_reg[idx_reg])
                     + (INT_W+2)'($signed(prod[PROD_W-1:DT_W]));
    always_comb
    begin
        if (integ_sum > (INT_W+2)'(INT_MAX))
        begin
            integ_sat = INT_MAX;
        end
        else if (integ_sum < (INT_W+2)'(INT_MIN))
        begin
            integ_sat = INT_MIN;
        end
        else
        begin
            integ_sat = integ_sum[INT_W-1:0];
        end
    end

    // truncating signed quotient, saturated
    assign quo_ext = 64'(div_quotient);
    always_comb
    begin
        if (quo_ext >= D_LIM)
        begin
            d_sat = neg_reg ? INT_MIN : INT_MAX;
        end
        else if (neg_reg)
        begin
            d_sat = -$signed(quo_ext[INT_W-1:0]);
        end
        else
        begin
            d_sat = $signed(quo_ext[INT_W-1:0]);
        end
    end

    assign prod_term = ACC_W'($signed(prod[PROD_W-1:8]));
    assign acc_sum   = acc_reg + prod_term;
    always_comb
    begin
        if (acc_sum > V_MAX)
        begin
            acc_sat = V_MAX;
        end
        else if (acc_sum < V_MIN)
        begin
            acc_sat = V_MIN;
        end
        else
        begin
            acc_sat = acc_sum;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_MULI:
            begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = MUL_B_W'({1'b0, dt_reg});
            end
            ST_INTG:
            begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = MUL_B_W'(kp);
            end
            ST_PROP:
            begin
                mul_a = i_reg;
                mul_b = MUL_B_W'(ki);
            end
            ST_DMUL:
            begin
                mul_a = d_reg;
                mul_b = MUL_B_W'(kd);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    vpid_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    vpid_div #(
        .DIVIDEND_W (DIVIDEND_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // gain registers
    always_comb
    begin
        gain_next = gain_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_POSITION:    gain_next[0] = cfg.wdata;
                REG_VELOCITY:    gain_next[1] = cfg.wdata;
                REG_ORIENTATION: gain_next[2] = cfg.wdata;
                default:         gain_next = gain_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        idx_next       = idx_reg;
        grp_next       = grp_reg;
        dt_next        = dt_reg;
        act_next       = act_reg;
        tgt_next       = tgt_reg;
        e_next         = e_reg;
        i_next         = i_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        drive_next     = drive_reg;
        out_group_next = out_group_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    grp_next       = req.vector_group;
                    out_group_next = req.vector_group;
                    dt_next        = req.step_time;
                    act_next[0]    = req.actual_x;
                    act_next[1]    = req.actual_y;
                    act_next[2]    = req.actual_z;
                    tgt_next[0]    = req.target_x;
                    tgt_next[1]    = req.target_y;
                    tgt_next[2]    = req.target_z;
                    axis_next      = '0;
                    if (grp_ok)
                    begin
                        idx_next   = IDX_W'(32'(req.vector_group) * AXES);
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        drive_next[0] = '0;
                        drive_next[1] = '0;
                        drive_next[2] = '0;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_ERR:
            begin
                e_next     = e_calc;
                state_next = ST_MULI;
            end
            ST_MULI:
            begin
                neg_next   = diff[EW];
                state_next = ST_INTG;
            end
            ST_INTG:
            begin
                i_next = (dt_reg != '0) ? integ_sat : integ_reg[idx_reg];
                integ_next[idx_reg] = i_next;
                prev_next[idx_reg]  = e_reg;
                state_next = ST_PROP;
            end
            ST_PROP:
            begin
                acc_next   = prod_term;
                state_next = ST_ITGM;
            end
            ST_ITGM:
            begin
                acc_next   = acc_sum;
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (!div_busy)
                begin
                    d_next     = (dt_reg != '0) ? d_sat : '0;
                    state_next = ST_DMUL;
                end
            end
            ST_DMUL:
            begin
                state_next = ST_ACCD;
            end
            ST_ACCD:
            begin
                drive_next[axis_reg] = VALUE_W'($signed(acc_sat[VAL_BITS-1:0]));
                if (axis_reg == 2'(AXES - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_ERR;
                end
            end
            ST_DONE:
            begin
                if (rsp_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            idx_reg   <= '0;
            for (int k = 0; k < GAIN_REGS; k++)
            begin
                gain_reg[k] <= '0;
            end
            for (int k = 0; k < STORE_DEPTH; k++)
            begin
                integ_reg[k] <= '0;
                prev_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            idx_reg   <= idx_next;
            gain_reg  <= gain_next;
            integ_reg <= integ_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg       <= grp_next;
        dt_reg        <= dt_next;
        act_reg       <= act_next;
        tgt_reg       <= tgt_next;
        e_reg         <= e_next;
        i_reg         <= i_next;
        d_reg         <= d_next;
        acc_reg       <= acc_next;
        neg_reg       <= neg_next;
        drive_reg     <= drive_next;
        out_group_reg <= out_group_next;
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = (state_reg == ST_DONE);
    assign rsp.out_group = out_group_reg;
    assign rsp.drive_x   = drive_reg[0];
    assign rsp.drive_y   = drive_reg[1];
    assign rsp.drive_z   = drive_reg[2];

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    a_bad_group: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && !grp_ok) |=> (rsp.valid && rsp.drive_x == '0
                                   && rsp.drive_y == '0 && rsp.drive_z == '0))
        else $error("invalid group did not give a zero result");

    a_last_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCD && axis_reg == 2'(AXES - 1)) |=> rsp.valid)
        else $error("result not presented after last axis");

    a_div_dt: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy)
        else $error("divider did not start");

endmodule

`default_nettype wire
